// File: hdl/vct_pkg.sv
// Shared types and character codes for the classic-encoding tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package vct_pkg;

   typedef enum logic [3:0] {
      KIND_SKIP     = 4'd0,
      KIND_IDENT    = 4'd1,
      KIND_NUMBER   = 4'd2,
      KIND_STRING   = 4'd3,
      KIND_LBRACE   = 4'd4,
      KIND_RBRACE   = 4'd5,
      KIND_LBRACKET = 4'd6,
      KIND_RBRACKET = 4'd7,
      KIND_UNKNOWN  = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic         start;
      logic         has;
      logic [7:0]   text;
      logic         eoi;
   } res_type;

   typedef struct packed {
      logic         two;
      res_type      first;
      res_type      second;
   } rec_type;

   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_APOS     = 8'h27;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_DIGIT0   = 8'h30;
   localparam logic [7:0] CH_DIGIT9   = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_E  = 8'h45;
   localparam logic [7:0] CH_UPPER_F  = 8'h46;
   localparam logic [7:0] CH_UPPER_X  = 8'h58;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_E  = 8'h65;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CH_LOWER_X  = 8'h78;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;

endpackage
`default_nettype wire

// File: hdl/vrml_classic_tokenizer_core.sv
// Top level of the classic-encoding byte tokenizer.
// Takes one text byte per cycle while req_stall is low and returns one word per byte
// that tags it with its token kind, token start and text byte; a backslash kept inside a
// string yields two words, which leave the output register one after the other. An accepted
// byte passes through the queue and then the output register before it shows up at
// rsp_valid. The scan mode lives in the front end and is updated in the same cycle that a
// byte is accepted; a queue of QUEUE_DEPTH records (at least 2) absorbs output stalls and
// the second word of a two-word byte, so req_stall rises only when it fills.
`timescale 1ns / 1ps
`default_nettype none
module vrml_classic_tokenizer_core
   import vct_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_token_kind,
   output logic             rsp_token_start,
   output logic             rsp_has_text,
   output logic [7:0]       rsp_text_byte,
   output logic             rsp_end_of_input,
   output logic             rsp_run_last
);

   logic    push_valid;
   rec_type push_data;
   logic    push_full;
   logic    q_valid;
   logic    q_pop;
   rec_type q_data;
   res_type res;

   assign req_stall = push_full;

   vct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   vct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_data)
   );

   vct_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res      (res),
      .rsp_run_last (rsp_run_last)
   );

   assign rsp_token_kind   = res.kind;
   assign rsp_token_start  = res.start;
   assign rsp_has_text     = res.has;
   assign rsp_text_byte    = res.text;
   assign rsp_end_of_input = res.eoi;

   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_text |-> rsp_text_byte == 8'd0)
      else $error("text byte set on a word without text");

   a_start_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_start |-> rsp_token_kind != KIND_SKIP)
      else $error("token start on a skipped byte");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=>
         rsp_valid && rsp_run_last && rsp_token_kind == KIND_STRING)
      else $error("second word of a kept backslash missing");

endmodule
`default_nettype wire

// File: hdl/vct_front.sv
// Front end: accepts bytes, tracks scan mode and builds one or two result words per byte.
`timescale 1ns / 1ps
`default_nettype none
module vct_front
   import vct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             push_valid,
   output rec_type          push_data
);

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_COMMENT = 6'b000010,
      MODE_NUMBER  = 6'b000100,
      MODE_IDENT   = 6'b001000,
      MODE_STRING  = 6'b010000,
      MODE_STR_ESC = 6'b100000
   } mode_type;

   typedef struct packed {
      mode_type mode;
      res_type  res;
   } step_type;

   mode_type mode_ff, mode_in;
   logic     exp_ff, exp_in;
   logic     accept;
   rec_type  rec;

   function automatic res_type make_res(input kind_type kind, input logic start,
                                        input logic has, input logic [7:0] c,
                                        input logic eoi);
      res_type r;
      r.kind  = kind;
      r.start = start;
      r.has   = has;
      r.text  = has ? c : 8'd0;
      r.eoi   = eoi;
      return r;
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      logic ok;
      ok = (c > CTRL_LIMIT);
      case (c) inside
         [CH_DIGIT0:CH_DIGIT9], CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
         CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_APOS, CH_HASH, CH_COMMA, CH_DOT,
         CH_BSLASH, CH_PLUS, CH_MINUS: ok = 1'b0;
         default: ;
      endcase
      return ok;
   endfunction

   function automatic logic is_ident_rest(input logic [7:0] c);
      logic ok;
      ok = (c > CTRL_LIMIT);
      case (c) inside
         CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN,
         CH_QUOTE, CH_APOS, CH_HASH, CH_COMMA, CH_BSLASH: ok = 1'b0;
         default: ;
      endcase
      return ok;
   endfunction

   function automatic logic is_number_rest(input logic [7:0] c, input logic after_exp);
      logic ok;
      case (c) inside
         [CH_DIGIT0:CH_DIGIT9], [CH_LOWER_A:CH_LOWER_F], [CH_UPPER_A:CH_UPPER_F],
         CH_DOT, CH_LOWER_X, CH_UPPER_X: ok = 1'b1;
         CH_PLUS, CH_MINUS: ok = after_exp;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic step_type dispatch(input logic [7:0] c, input logic eoi);
      step_type s;
      s.mode = MODE_IDLE;
      s.res  = make_res(KIND_SKIP, 1'b0, 1'b0, c, eoi);
      case (c) inside
         CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA: ;
         CH_HASH: s.mode = MODE_COMMENT;
         CH_LBRACE:   s.res = make_res(KIND_LBRACE, 1'b1, 1'b1, c, eoi);
         CH_RBRACE:   s.res = make_res(KIND_RBRACE, 1'b1, 1'b1, c, eoi);
         CH_LBRACKET: s.res = make_res(KIND_LBRACKET, 1'b1, 1'b1, c, eoi);
         CH_RBRACKET: s.res = make_res(KIND_RBRACKET, 1'b1, 1'b1, c, eoi);
         CH_QUOTE: begin
            s.mode = MODE_STRING;
            s.res  = make_res(KIND_STRING, 1'b1, 1'b0, c, eoi);
         end
         CH_MINUS, CH_PLUS, CH_DOT, [CH_DIGIT0:CH_DIGIT9]: begin
            s.mode = MODE_NUMBER;
            s.res  = make_res(KIND_NUMBER, 1'b1, 1'b1, c, eoi);
         end
         default: begin
            if (is_ident_start(c)) begin
               s.mode = MODE_IDENT;
               s.res  = make_res(KIND_IDENT, 1'b1, 1'b1, c, eoi);
            end else begin
               s.res  = make_res(KIND_UNKNOWN, 1'b1, 1'b1, c, eoi);
            end
         end
      endcase
      return s;
   endfunction

   function automatic step_type string_byte(input logic [7:0] c, input logic eoi);
      step_type s;
      s.mode = MODE_STRING;
      s.res  = make_res(KIND_STRING, 1'b0, 1'b1, c, eoi);
      if (c == CH_QUOTE) begin
         s.mode = MODE_IDLE;
         s.res  = make_res(KIND_STRING, 1'b0, 1'b0, c, eoi);
      end else if (c == CH_BSLASH && !eoi) begin
         s.mode = MODE_STR_ESC;
         s.res  = make_res(KIND_STRING, 1'b0, 1'b0, c, eoi);
      end
      return s;
   endfunction

   always_comb begin
      step_type s;
      s             = dispatch(req_in_byte, req_in_last);
      mode_in       = mode_ff;
      exp_in        = exp_ff;
      rec.two       = 1'b0;
      rec.first     = make_res(KIND_SKIP, 1'b0, 1'b0, req_in_byte, req_in_last);
      rec.second    = rec.first;
      unique case (mode_ff)
         MODE_COMMENT: begin
            if (req_in_byte == CH_LF) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_number_rest(req_in_byte, exp_ff)) begin
               exp_in    = (req_in_byte == CH_LOWER_E) || (req_in_byte == CH_UPPER_E);
               rec.first = make_res(KIND_NUMBER, 1'b0, 1'b1, req_in_byte, req_in_last);
            end else begin
               exp_in    = 1'b0;
               mode_in   = s.mode;
               rec.first = s.res;
            end
         end
         MODE_IDENT: begin
            if (is_ident_rest(req_in_byte)) begin
               rec.first = make_res(KIND_IDENT, 1'b0, 1'b1, req_in_byte, req_in_last);
            end else begin
               exp_in    = 1'b0;
               mode_in   = s.mode;
               rec.first = s.res;
            end
         end
         MODE_STRING: begin
            s         = string_byte(req_in_byte, req_in_last);
            mode_in   = s.mode;
            rec.first = s.res;
         end
         MODE_STR_ESC: begin
            if (req_in_byte == CH_QUOTE || req_in_byte == CH_BSLASH) begin
               mode_in   = MODE_STRING;
               rec.first = make_res(KIND_STRING, 1'b0, 1'b1, req_in_byte, req_in_last);
            end else begin
               s          = string_byte(req_in_byte, req_in_last);
               mode_in    = s.mode;
               rec.two    = 1'b1;
               rec.first  = make_res(KIND_STRING, 1'b0, 1'b1, CH_BSLASH, req_in_last);
               rec.second = s.res;
            end
         end
         default: begin
            exp_in    = 1'b0;
            mode_in   = s.mode;
            rec.first = s.res;
         end
      endcase
      if (req_in_last) begin
         mode_in = MODE_IDLE;
         exp_in  = 1'b0;
      end
   end

   assign accept     = req_valid && !req_stall;
   assign push_valid = accept;
   assign push_data  = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         exp_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         exp_ff  <= exp_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/vct_queue.sv
// Short queue of result records between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module vct_queue
   import vct_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  rec_type      push_data,
   output logic         push_full,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output rec_type      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/vct_back.sv
// Back end: splits queued records into result words and holds them in the output register.
`timescale 1ns / 1ps
`default_nettype none
module vct_back
   import vct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  rec_type          q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output res_type          rsp_res,
   output logic             rsp_run_last
);

   logic    valid_ff, valid_in;
   logic    phase_ff, phase_in;
   res_type res_ff, res_in;
   logic    run_last_ff, run_last_in;
   logic    out_free;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in    = valid_ff;
      phase_in    = phase_ff;
      res_in      = res_ff;
      run_last_in = run_last_ff;
      q_pop       = 1'b0;
      if (out_free) begin
         valid_in = q_valid;
         if (q_valid) begin
            if (!phase_ff) begin
               res_in      = q_data.first;
               run_last_in = !q_data.two;
               phase_in    = q_data.two;
               q_pop       = !q_data.two;
            end else begin
               res_in      = q_data.second;
               run_last_in = 1'b1;
               phase_in    = 1'b0;
               q_pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res      = res_ff;
   assign rsp_run_last = run_last_ff;

endmodule
`default_nettype wire
